// ===== rtl/core/pixel_affine_correction_and_weight_core_macros.svh =====
// Assertion macros shared by the pixel correction core.
`ifndef PIXEL_AFFINE_CORRECTION_AND_WEIGHT_CORE_MACROS_SVH
`define PIXEL_AFFINE_CORRECTION_AND_WEIGHT_CORE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define PAW_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("paw core check failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define PAW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("paw core implication failed");

`endif

// ===== rtl/core/paw_pkg.sv =====
// Types and constants of the pixel correction and weight core.
`timescale 1ns / 1ps

package paw_pkg;

  typedef enum logic {
    ModeSubMul = 1'b0,
    ModeMulAdd = 1'b1
  } mode_e;

  localparam int unsigned DivSteps = 24;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic signed [23:0] CorrMax = 24'sh7FFFFF;
  localparam logic signed [23:0] CorrMin = -24'sh800000;
  localparam logic [23:0]        WgtMax  = 24'hFFFFFF;

  typedef struct packed {
    logic signed [23:0] corr;
    logic               sat;
    logic               dz;
    logic               ovf;
    logic [24:0]        den;
    logic [23:0]        num;
  } item_t;

  typedef struct packed {
    logic signed [23:0] corr;
    logic               sat;
    logic               dz;
    logic               ovf;
    logic [24:0]        den;
    logic [24:0]        rem;
    logic [23:0]        quo;
    logic [23:0]        dd;
  } div_stage_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } q_status_t;

endpackage

// ===== rtl/core/pixel_affine_correction_and_weight_core.sv =====
// Top level of the pixel affine correction and inverse-variance weight core.
//
//   channel  direction  handshake                 beat contents
//   in       input      in_valid_i / in_stall_o   pixel, gain, offset, numerator, floor
//   out      output     out_valid_o / out_stall_i corrected, weight, saturated, div by 0
//   cfg      input      cfg_valid_i / cfg_ready_o correction mode bit
//
// The core takes one beat per clock while in_stall_o is low and gives one result
// beat per clock while out_stall_i is low. A beat passes three front-end stages, the
// queue and 24 divider stages, one quotient bit each. The four-entry queue lets the
// front end keep accepting while the output is stalled, until it and the queue fill.
// Reset clears the mode to subtract-then-multiply and empties all pipelines.
`timescale 1ns / 1ps
`include "pixel_affine_correction_and_weight_core_macros.svh"

module pixel_affine_correction_and_weight_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         pixel_i,
  input  logic [15:0]        gain_i,
  input  logic signed [15:0] offset_i,
  input  logic [23:0]        weight_numerator_i,
  input  logic [23:0]        noise_floor_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] corrected_o,
  output logic [23:0]        weight_o,
  output logic               saturated_o,
  output logic               divide_by_zero_o
);

  paw_pkg::mode_e     mode_q;
  logic               push;
  logic               pop;
  paw_pkg::item_t     push_item;
  paw_pkg::item_t     head_item;
  paw_pkg::q_status_t q_status;

  logic                      dz_beat;
  logic                      dz_forced;
  logic [paw_pkg::QCntW-1:0] q_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= paw_pkg::ModeSubMul;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= paw_pkg::mode_e'(cfg_data_i);
    end
  end

  paw_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .mode_i             (mode_q),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .pixel_i            (pixel_i),
    .gain_i             (gain_i),
    .offset_i           (offset_i),
    .weight_numerator_i (weight_numerator_i),
    .noise_floor_i      (noise_floor_i),
    .q_full_i           (q_status.full),
    .push_o             (push),
    .item_o             (push_item)
  );

  paw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  paw_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (head_item),
    .q_empty_i        (q_status.empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .corrected_o      (corrected_o),
    .weight_o         (weight_o),
    .saturated_o      (saturated_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  assign dz_beat   = out_valid_o && divide_by_zero_o;
  assign dz_forced = (weight_o == paw_pkg::WgtMax) && saturated_o;
  assign q_cnt     = q_status.count;

  // The queue count moves by at most one per clock.
  `PAW_ASSERT_IMPL(a_dz_forces_max, dz_beat, dz_forced)
  `PAW_ASSERT(a_queue_bound, q_cnt <= paw_pkg::QCntW'(paw_pkg::QDepth))
  `PAW_ASSERT(a_queue_step, (q_cnt - $past(q_cnt) + 3'd1) <= 3'd2)

endmodule

// ===== rtl/core/paw_front.sv =====
// Front end: accepts pixels, forms the corrected value and classifies the weight divide.
`timescale 1ns / 1ps

module paw_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  paw_pkg::mode_e        mode_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            pixel_i,
  input  logic [15:0]           gain_i,
  input  logic signed [15:0]    offset_i,
  input  logic [23:0]           weight_numerator_i,
  input  logic [23:0]           noise_floor_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output paw_pkg::item_t        item_o
);

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_ready, s2_ready, s3_ready;

  logic signed [17:0] opa;
  logic signed [16:0] gain_s;
  logic signed [34:0] prod_d, prod_q;
  paw_pkg::mode_e     s1_mode_q;
  logic signed [15:0] s1_off_q;
  logic [23:0]        s1_num_q, s1_floor_q;

  logic signed [34:0] off_sh;
  logic signed [34:0] sum;
  logic signed [34:0] shifted;
  logic signed [23:0] corr_d, s2_corr_q;
  logic               sat_d, s2_sat_q;
  logic [23:0]        s2_num_q, s2_floor_q;

  logic [24:0]        corr_pos;
  logic [24:0]        den;
  paw_pkg::item_t     item_d, item_q;

  assign s3_ready   = !s3_v_q || !q_full_i;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign push_o     = s3_v_q && !q_full_i;
  assign item_o     = item_q;

  always_comb begin
    gain_s = $signed({1'b0, gain_i});
    if (mode_i == paw_pkg::ModeMulAdd) begin
      opa = $signed({10'd0, pixel_i});
    end else begin
      opa = $signed({3'd0, pixel_i, 7'd0}) - $signed({{2{offset_i[15]}}, offset_i});
    end
    prod_d = opa * gain_s;
  end

  always_comb begin
    off_sh = $signed({{14{s1_off_q[15]}}, s1_off_q, 5'd0});
    if (s1_mode_q == paw_pkg::ModeMulAdd) begin
      sum     = prod_q + off_sh;
      shifted = sum >>> 4;
    end else begin
      sum     = prod_q;
      shifted = sum >>> 11;
    end
    if (shifted > paw_pkg::CorrMax) begin
      corr_d = paw_pkg::CorrMax;
      sat_d  = 1'b1;
    end else if (shifted < paw_pkg::CorrMin) begin
      corr_d = paw_pkg::CorrMin;
      sat_d  = 1'b1;
    end else begin
      corr_d = shifted[23:0];
      sat_d  = 1'b0;
    end
  end

  always_comb begin
    corr_pos    = s2_corr_q[23] ? 25'd0 : {1'b0, s2_corr_q};
    den         = corr_pos + {1'b0, s2_floor_q};
    item_d.corr = s2_corr_q;
    item_d.sat  = s2_sat_q;
    item_d.dz   = (den == 25'd0);
    item_d.ovf  = ({17'd0, s2_num_q[23:16]} >= den);
    item_d.den  = den;
    item_d.num  = s2_num_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      prod_q     <= prod_d;
      s1_mode_q  <= mode_i;
      s1_off_q   <= offset_i;
      s1_num_q   <= weight_numerator_i;
      s1_floor_q <= noise_floor_i;
    end
    if (s2_ready && s1_v_q) begin
      s2_corr_q  <= corr_d;
      s2_sat_q   <= sat_d;
      s2_num_q   <= s1_num_q;
      s2_floor_q <= s1_floor_q;
    end
    if (s3_ready && s2_v_q) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/core/paw_queue.sv =====
// Short queue that decouples the front end from the divider pipeline.
`timescale 1ns / 1ps

module paw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  paw_pkg::item_t      item_i,
  input  logic                pop_i,
  output paw_pkg::item_t      item_o,
  output paw_pkg::q_status_t  status_o
);

  paw_pkg::item_t                  mem_q [paw_pkg::QDepth];
  logic [paw_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [paw_pkg::QCntW-1:0]       count_q, count_d;

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.full  = (count_q == paw_pkg::QCntW'(paw_pkg::QDepth));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/paw_back.sv =====
// Back end: pipelined restoring divider that forms the weight, one quotient bit per stage.
`timescale 1ns / 1ps

module paw_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  paw_pkg::item_t             item_i,
  input  logic                       q_empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [23:0]         corrected_o,
  output logic [23:0]                weight_o,
  output logic                       saturated_o,
  output logic                       divide_by_zero_o
);

  localparam int unsigned Last = paw_pkg::DivSteps - 1;

  logic                 v_q  [paw_pkg::DivSteps];
  paw_pkg::div_stage_t  st_q [paw_pkg::DivSteps];
  logic                 advance;
  paw_pkg::div_stage_t  head;

  function automatic paw_pkg::div_stage_t div_step(input paw_pkg::div_stage_t s);
    paw_pkg::div_stage_t r;
    logic [25:0]         t;
    logic [25:0]         diff;
    logic                ge;
    r    = s;
    t    = {s.rem, s.dd[23]};
    diff = t - {1'b0, s.den};
    ge   = (t >= {1'b0, s.den});
    r.rem = ge ? diff[24:0] : t[24:0];
    r.quo = {s.quo[22:0], ge};
    r.dd  = {s.dd[22:0], 1'b0};
    return r;
  endfunction

  always_comb begin
    head.corr = item_i.corr;
    head.sat  = item_i.sat;
    head.dz   = item_i.dz;
    head.ovf  = item_i.ovf;
    head.den  = item_i.den;
    head.rem  = {17'd0, item_i.num[23:16]};
    head.quo  = '0;
    head.dd   = {item_i.num[15:0], 8'd0};
  end

  assign out_valid_o = v_q[Last];
  assign advance     = !v_q[Last] || !out_stall_i;
  assign pop_o       = advance && !q_empty_i;

  assign corrected_o      = st_q[Last].corr;
  assign weight_o         = (st_q[Last].dz || st_q[Last].ovf) ? paw_pkg::WgtMax
                                                               : st_q[Last].quo;
  assign saturated_o      = st_q[Last].sat || st_q[Last].dz || st_q[Last].ovf;
  assign divide_by_zero_o = st_q[Last].dz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < paw_pkg::DivSteps; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (advance) begin
      v_q[0] <= !q_empty_i;
      for (int i = 1; i < paw_pkg::DivSteps; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_q[0] <= div_step(head);
      for (int i = 1; i < paw_pkg::DivSteps; i++) begin
        st_q[i] <= div_step(st_q[i-1]);
      end
    end
  end

endmodule

// ===== sim/pixel_affine_correction_and_weight_core_tb.sv =====
// Self-checking testbench for the pixel affine correction and weight core.
`timescale 1ns / 1ps

module pixel_affine_correction_and_weight_core_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned SegItems = 250;
  localparam int unsigned NumSegs = 6;

  typedef struct packed {
    logic signed [23:0] corr;
    logic [23:0]        wgt;
    logic               sat;
    logic               dz;
  } pixel_result_t;

  class paw_scoreboard;
    paw_pkg::mode_e mode;
    pixel_result_t  expected_q[$];
    int unsigned    errors;

    function new();
      mode = paw_pkg::ModeSubMul;
      errors = 0;
    endfunction

    function pixel_result_t correct_pixel(logic [7:0] pixel, logic [15:0] gain,
                                          logic signed [15:0] offset, logic [23:0] num,
                                          logic [23:0] nfloor);
      longint            t;
      longint            c;
      longint unsigned   den;
      longint unsigned   q;
      pixel_result_t     r;
      r.sat = 1'b0;
      r.dz = 1'b0;
      if (mode == paw_pkg::ModeSubMul) begin
        t = (longint'(pixel) * 128 - longint'(offset)) * longint'(gain);
        c = t >>> 11;
      end else begin
        t = longint'(pixel) * longint'(gain) + longint'(offset) * 32;
        c = t >>> 4;
      end
      if (c > longint'(paw_pkg::CorrMax)) begin
        c = longint'(paw_pkg::CorrMax);
        r.sat = 1'b1;
      end else if (c < longint'(paw_pkg::CorrMin)) begin
        c = longint'(paw_pkg::CorrMin);
        r.sat = 1'b1;
      end
      if (c > 0) begin
        den = longint'(c) + longint'(nfloor);
      end else begin
        den = longint'(nfloor);
      end
      if (den == 0) begin
        q = longint'(paw_pkg::WgtMax);
        r.dz = 1'b1;
        r.sat = 1'b1;
      end else begin
        q = (longint'(num) << 8) / den;
        if (q > longint'(paw_pkg::WgtMax)) begin
          q = longint'(paw_pkg::WgtMax);
          r.sat = 1'b1;
        end
      end
      r.corr = c[23:0];
      r.wgt = q[23:0];
      return r;
    endfunction

    function void note_pixel(logic [7:0] pixel, logic [15:0] gain, logic signed [15:0] offset,
                             logic [23:0] num, logic [23:0] nfloor);
      expected_q.push_back(correct_pixel(pixel, gain, offset, num, nfloor));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [23:0] corr, logic [23:0] wgt, logic sat, logic dz);
      pixel_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result corr=%h wgt=%h sat=%b dz=%b", corr, wgt, sat, dz));
      end else begin
        e = expected_q.pop_front();
        if (corr !== e.corr || wgt !== e.wgt || sat !== e.sat || dz !== e.dz) begin
          report($sformatf("corr=%h/%h wgt=%h/%h sat=%b/%b dz=%b/%b (got/expected)",
                           corr, e.corr, wgt, e.wgt, sat, e.sat, dz, e.dz));
        end
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         pixel_i;
  logic [15:0]        gain_i;
  logic signed [15:0] offset_i;
  logic [23:0]        weight_numerator_i;
  logic [23:0]        noise_floor_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [23:0] corrected_o;
  logic [23:0]        weight_o;
  logic               saturated_o;
  logic               divide_by_zero_o;

  paw_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  bit            tx_idle = 1'b0;
  bit            rx_idle = 1'b0;
  bit            long_hold_req = 1'b0;

  pixel_affine_correction_and_weight_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .pixel_i            (pixel_i),
    .gain_i             (gain_i),
    .offset_i           (offset_i),
    .weight_numerator_i (weight_numerator_i),
    .noise_floor_i      (noise_floor_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .corrected_o        (corrected_o),
    .weight_o           (weight_o),
    .saturated_o        (saturated_o),
    .divide_by_zero_o   (divide_by_zero_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("pixel_affine_correction_and_weight_core_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_pixel(pixel_i, gain_i, offset_i, weight_numerator_i, noise_floor_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(corrected_o, weight_o, saturated_o, divide_by_zero_o);
      end
    end
  end

  // The long hold-off keeps the output stalled so the pipeline and queue fill up.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_idle && stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] pick_field(int unsigned bits);
    logic [31:0] mask;
    int unsigned sel;
    mask = (32'h1 << bits) - 1;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'h0;
    if (sel == 1) return mask;
    return $urandom & mask;
  endfunction

  task automatic send_pixel(logic [7:0] p, logic [15:0] g, logic [15:0] o, logic [23:0] n,
                            logic [23:0] f);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= p;
    gain_i <= g;
    offset_i <= o;
    weight_numerator_i <= n;
    noise_floor_i <= f;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(paw_pkg::mode_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.mode = m;
    cfg_valid_i <= 1'b0;
  endtask

  // Extremes, zero denominators, weight overflow and negative flooring.
  task automatic send_directed();
    send_pixel(8'd0, 16'd0, 16'h0000, 24'h000000, 24'h000000);
    send_pixel(8'd255, 16'hFFFF, 16'h8000, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(8'd255, 16'hFFFF, 16'h7FFF, 24'hFFFFFF, 24'h000000);
    send_pixel(8'd0, 16'd1, 16'h0001, 24'hFFFFFF, 24'h000001);
    send_pixel(8'd0, 16'd3, 16'h0005, 24'h000000, 24'hFFFFFF);
    send_pixel(8'd128, 16'h1000, 16'h0000, 24'h010000, 24'h000000);
    send_pixel(8'd1, 16'd0, 16'hFFFF, 24'h000001, 24'h000000);
    send_pixel(8'd200, 16'h8000, 16'h1234, 24'hABCDEF, 24'h000100);
    send_pixel(8'd0, 16'd0, 16'h0000, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(8'd255, 16'hFFFF, 16'h0000, 24'h000000, 24'h000000);
    send_pixel(8'd0, 16'hFFFF, 16'h8000, 24'h800000, 24'h800000);
  endtask

  task automatic send_random_pixel();
    logic [23:0] f;
    if ($urandom_range(0, 7) == 0) begin
      f = 24'($urandom_range(0, 3));
    end else begin
      f = 24'(pick_field(24));
    end
    send_pixel(8'(pick_field(8)), 16'(pick_field(16)), 16'(pick_field(16)),
               24'(pick_field(24)), f);
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 1'b0;
    in_valid_i <= 1'b0;
    pixel_i <= '0;
    gain_i <= '0;
    offset_i <= '0;
    weight_numerator_i <= '0;
    noise_floor_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_directed();
    drain_results();
    write_mode(paw_pkg::ModeMulAdd);
    send_directed();
    drain_results();

    for (int seg = 0; seg < NumSegs; seg++) begin
      write_mode(seg % 2 == 0 ? paw_pkg::ModeSubMul : paw_pkg::ModeMulAdd);
      tx_idle = (seg != 1) && (seg < NumSegs - 1);
      rx_idle = tx_idle;
      if (seg == 2) long_hold_req = 1'b1;
      for (int i = 0; i < SegItems; i++) send_random_pixel();
      drain_results();
    end

    if (sb.pending() != 0) sb.report("results still expected at end of run");
    if (sb.errors == 0) begin
      $display("pixel_affine_correction_and_weight_core_tb: PASS");
    end else begin
      $display("pixel_affine_correction_and_weight_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== pixel_affine_correction_and_weight_core.f =====
+incdir+rtl/core
rtl/core/paw_pkg.sv
rtl/core/paw_front.sv
rtl/core/paw_queue.sv
rtl/core/paw_back.sv
rtl/core/pixel_affine_correction_and_weight_core.sv
sim/pixel_affine_correction_and_weight_core_tb.sv
